// ----- src/pcxrd_pkg.sv -----
// shared constants, codes and control/status types of the pcx byte run decoder
package pcxrd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int BYTE_W     = 8;
    localparam int OFFSET_W   = 26;
    localparam int COUNT_W    = 6;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int PLANE_W    = 2;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_RGB    = 2'd2;

    localparam logic [CFG_DATA_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RST_HEIGHT = 13'd480;

    localparam logic [1:0]         MARKER_TAG = 2'b11;
    localparam logic [PLANE_W-1:0] PLANE_BLUE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic at_input;   // controller is in its input-taking state
        logic take;       // input request accepted this cycle
        logic emit;       // produce one pixel at the current position
        logic last;       // emitted pixel is the final one for its input request
        logic mark;       // store a run marker
        logic run_load;   // consume pending run count into the run counter
        logic halt;       // image ends without output
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic done;
        logic awaiting;
        logic marker;
        logic count_zero;
        logic count_one;
        logic row_ovf;
        logic completes;
        logic remain_one;
        logic slot_free;
    } t_status;

endpackage

// ----- src/pcxrd_ctrl.sv -----
// controller state machine of the pcx byte run decoder
module pcxrd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  pcxrd_pkg::t_status i_status,
    output logic               o_ready,
    output pcxrd_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_ready        = 1'b0;
        o_cmd.at_input = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_ready = i_status.slot_free;
                if (i_valid && i_status.slot_free) begin
                    o_cmd.take = 1'b1;
                    if (i_status.done) begin
                        // image finished: byte dropped
                    end else if (i_status.awaiting) begin
                        o_cmd.run_load = 1'b1;
                        if (!i_status.count_zero) begin
                            if (i_status.row_ovf) begin
                                o_cmd.halt = 1'b1;
                            end else begin
                                o_cmd.emit = 1'b1;
                                o_cmd.last = i_status.count_one | i_status.completes;
                                if (!o_cmd.last) begin
                                    n_state = ST_RUN;
                                end
                            end
                        end
                    end else if (i_status.marker) begin
                        o_cmd.mark = 1'b1;
                    end else if (i_status.row_ovf) begin
                        o_cmd.halt = 1'b1;
                    end else begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = i_status.remain_one | i_status.completes;
                    if (o_cmd.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/pcxrd_dp.sv -----
// datapath of the pcx byte run decoder: config, position, run counter, offset, output register
module pcxrd_dp #(
    parameter int MaxWidth  = pcxrd_pkg::DEF_MAX_WIDTH,
    parameter int MaxHeight = pcxrd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcxrd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcxrd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [pcxrd_pkg::BYTE_W-1:0]        i_code_byte,
    input  logic                                i_frame_start,
    input  pcxrd_pkg::t_cmd                     i_cmd,
    output pcxrd_pkg::t_status                  o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [pcxrd_pkg::BYTE_W-1:0]        o_pixel_byte,
    output logic [pcxrd_pkg::OFFSET_W-1:0]      o_dest_offset,
    output logic                                o_last_of_input,
    output logic                                o_image_complete
);

    localparam int CW = $clog2(MaxWidth);
    localparam int WW = $clog2(MaxWidth + 1);
    localparam int RW = $clog2(MaxHeight + 1);
    localparam int OW = pcxrd_pkg::OFFSET_W;
    localparam int NW = pcxrd_pkg::COUNT_W;
    localparam int PW = pcxrd_pkg::PLANE_W;

    logic [pcxrd_pkg::CFG_DATA_W-1:0] r_image_width;
    logic [pcxrd_pkg::CFG_DATA_W-1:0] r_image_height;
    logic                             r_rgb_mode;

    logic          r_awaiting;
    logic [NW-1:0] r_run_count;
    logic [NW-1:0] r_remain;
    logic [CW-1:0] r_column;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_plane;
    logic          r_done;
    logic [pcxrd_pkg::BYTE_W-1:0] r_value;

    logic                         r_out_valid;
    logic [pcxrd_pkg::BYTE_W-1:0] r_out_byte;
    logic [OW-1:0]                r_out_offset;
    logic                         r_out_last;
    logic                         r_out_complete;

    logic          clr;
    logic          awaiting_eff;
    logic          done_eff;
    logic [NW-1:0] count_eff;
    logic [CW-1:0] col_eff;
    logic [RW-1:0] row_eff;
    logic [PW-1:0] plane_eff;
    logic [PW-1:0] plane_sel;
    logic [WW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic [CW:0]   col_inc;
    logic [RW-1:0] row_inc;
    logic          wrap;
    logic          row_adv;
    logic          completes;
    logic [OW-1:0] line_base;
    logic [OW-1:0] pix_index;
    logic [OW-1:0] offset;
    logic [pcxrd_pkg::BYTE_W-1:0] emit_value;

    // frame start clears position before the byte that carries it
    assign clr          = i_cmd.at_input & i_frame_start;
    assign awaiting_eff = clr ? 1'b0 : r_awaiting;
    assign done_eff     = clr ? 1'b0 : r_done;
    assign count_eff    = clr ? '0 : r_run_count;
    assign col_eff      = clr ? '0 : r_column;
    assign row_eff      = clr ? '0 : r_row;
    assign plane_eff    = clr ? '0 : r_plane;

    // clamp geometry into 1..max
    always_comb begin
        if (r_image_width == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_image_width) > 32'(MaxWidth)) begin
            w_eff = WW'(MaxWidth);
        end else begin
            w_eff = WW'(r_image_width);
        end
        if (r_image_height == '0) begin
            h_eff = RW'(1);
        end else if (32'(r_image_height) > 32'(MaxHeight)) begin
            h_eff = RW'(MaxHeight);
        end else begin
            h_eff = RW'(r_image_height);
        end
    end

    assign col_inc   = {1'b0, col_eff} + (CW+1)'(1);
    assign row_inc   = row_eff + RW'(1);
    assign wrap      = 32'(col_inc) >= 32'(w_eff);
    assign row_adv   = wrap & ~(r_rgb_mode & (plane_eff < pcxrd_pkg::PLANE_BLUE));
    assign completes = row_adv & (32'(row_inc) >= 32'(h_eff));
    assign plane_sel = (plane_eff > pcxrd_pkg::PLANE_BLUE) ? pcxrd_pkg::PLANE_BLUE : plane_eff;

    // only the low offset bits are kept, so the product is formed at offset width
    assign line_base = OW'(row_eff) * OW'(w_eff);
    assign pix_index = line_base + OW'(col_eff);
    assign offset    = r_rgb_mode ? (pix_index + (pix_index << 1) + OW'(plane_sel)) : pix_index;

    assign emit_value = i_cmd.at_input ? i_code_byte : r_value;

    always_comb begin
        o_status            = '0;
        o_status.done       = done_eff;
        o_status.awaiting   = awaiting_eff;
        o_status.marker     = (i_code_byte[pcxrd_pkg::BYTE_W-1 -: 2] == pcxrd_pkg::MARKER_TAG);
        o_status.count_zero = (count_eff == '0);
        o_status.count_one  = (count_eff == NW'(1));
        o_status.row_ovf    = 32'(row_eff) >= 32'(h_eff);
        o_status.completes  = completes;
        o_status.remain_one = (r_remain == NW'(1));
        o_status.slot_free  = ~r_out_valid | i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= pcxrd_pkg::RST_WIDTH;
            r_image_height <= pcxrd_pkg::RST_HEIGHT;
            r_rgb_mode     <= 1'b0;
            r_awaiting     <= 1'b0;
            r_run_count    <= '0;
            r_remain       <= '0;
            r_column       <= '0;
            r_row          <= '0;
            r_plane        <= '0;
            r_done         <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pcxrd_pkg::CFG_IDX_WIDTH:  r_image_width  <= i_cfg_data;
                    pcxrd_pkg::CFG_IDX_HEIGHT: r_image_height <= i_cfg_data;
                    pcxrd_pkg::CFG_IDX_RGB:    r_rgb_mode     <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.take && i_frame_start) begin
                r_awaiting  <= 1'b0;
                r_run_count <= '0;
                r_column    <= '0;
                r_row       <= '0;
                r_plane     <= '0;
                r_done      <= 1'b0;
            end
            if (i_cmd.mark) begin
                r_awaiting  <= 1'b1;
                r_run_count <= i_code_byte[NW-1:0];
            end
            if (i_cmd.run_load) begin
                r_awaiting  <= 1'b0;
                r_run_count <= '0;
                r_remain    <= count_eff - NW'(1);
            end else if (i_cmd.emit && !i_cmd.at_input) begin
                r_remain <= r_remain - NW'(1);
            end
            if (i_cmd.halt) begin
                r_done <= 1'b1;
            end
            if (i_cmd.emit) begin
                if (wrap) begin
                    r_column <= '0;
                    if (row_adv) begin
                        r_plane <= '0;
                        r_row   <= row_inc;
                    end else begin
                        r_plane <= plane_eff + PW'(1);
                    end
                end else begin
                    r_column <= col_inc[CW-1:0];
                end
                if (completes) begin
                    r_done <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_value <= i_code_byte;
        end
        if (i_cmd.emit) begin
            r_out_byte     <= emit_value;
            r_out_offset   <= offset;
            r_out_last     <= i_cmd.last;
            r_out_complete <= completes;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_pixel_byte     = r_out_byte;
    assign o_dest_offset    = r_out_offset;
    assign o_last_of_input  = r_out_last;
    assign o_image_complete = r_out_complete;

endmodule

// ----- src/pcx_byte_run_decoder.sv -----
// top level of the pcx byte run decoder
// Usage: compressed bytes enter on the s_axis channel, one byte per request,
// tuser set on the first byte of a frame to restart at offset zero. A byte
// with both top bits set is a run marker (low six bits = repeat count) and
// the following byte is repeated; any other byte is a literal pixel.
// Each decoded pixel leaves on m_axis with its destination byte offset;
// tlast marks the final pixel caused by one input byte and tuser marks the
// pixel that fills the last position of the image.
// Geometry and rgb mode come from the write port; the user must see that
// they are changed between requests only, as the block does not enforce it.
// A byte's first pixel is registered and is valid in the cycle after that byte.
// Literals, markers and dropped bytes are each taken in one handshake; a run
// holds the input while its pixels leave, one pixel per cycle while the
// receiver is ready, as every pixel passes through the single output register.
// The offset is one row-times-width product plus adds per pixel.
// A stalled receiver holds the output register and, through it, the input.
// Reset restores 640 x 480 single-plane geometry and clears all frame state.
module pcx_byte_run_decoder #(
    parameter int MaxWidth  = pcxrd_pkg::DEF_MAX_WIDTH,
    parameter int MaxHeight = pcxrd_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [pcxrd_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,  // [7:0] code_byte
    input  logic                                 i_s_axis_tuser,  // [0] frame_start
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [pcxrd_pkg::M_TDATA_W-1:0]      o_m_axis_tdata,  // [7:0] pixel_byte, [33:8] dest_offset
    output logic                                 o_m_axis_tlast,  // last_of_input
    output logic                                 o_m_axis_tuser,  // [0] image_complete
    input  logic                                 i_cfg_we,
    input  logic [pcxrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcxrd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pcxrd_pkg::t_cmd    cmd;
    pcxrd_pkg::t_status status;

    logic [pcxrd_pkg::BYTE_W-1:0]   pixel_byte;
    logic [pcxrd_pkg::OFFSET_W-1:0] dest_offset;

    pcxrd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .i_status (status),
        .o_ready  (o_s_axis_tready),
        .o_cmd    (cmd)
    );

    pcxrd_dp #(
        .MaxWidth  (MaxWidth),
        .MaxHeight (MaxHeight)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_code_byte      (i_s_axis_tdata[pcxrd_pkg::BYTE_W-1:0]),
        .i_frame_start    (i_s_axis_tuser),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_out_ready      (i_m_axis_tready),
        .o_out_valid      (o_m_axis_tvalid),
        .o_pixel_byte     (pixel_byte),
        .o_dest_offset    (dest_offset),
        .o_last_of_input  (o_m_axis_tlast),
        .o_image_complete (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {
        {(pcxrd_pkg::M_TDATA_W - pcxrd_pkg::OFFSET_W - pcxrd_pkg::BYTE_W){1'b0}},
        dest_offset,
        pixel_byte
    };

endmodule

// ----- tb/pcx_pixel_checker.sv -----
// checker for the pcx byte run decoder: tracks registers and frame position, predicts pixels
module pcx_pixel_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [pcxrd_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [pcxrd_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input  logic                             i_m_tlast,
    input  logic                             i_m_tuser,
    input  logic                             i_cfg_we,
    input  logic [pcxrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcxrd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_bytes,
    output int                               o_pixels,
    output int                               o_images
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [pcxrd_pkg::BYTE_W-1:0]   value;
        logic [pcxrd_pkg::OFFSET_W-1:0] offset;
        logic                           run_end;
        logic                           fills_image;
    } t_pixel;

    t_pixel want_q[$];

    logic [pcxrd_pkg::CFG_DATA_W-1:0] width_reg;
    logic [pcxrd_pkg::CFG_DATA_W-1:0] height_reg;
    logic                             rgb_reg;

    logic                             wait_value;
    logic [pcxrd_pkg::COUNT_W-1:0]    run_left;
    int unsigned                      col;
    int unsigned                      row;
    int unsigned                      plane;
    logic                             img_done;

    function automatic void clear_position();
        wait_value = 1'b0;
        run_left   = '0;
        col        = 0;
        row        = 0;
        plane      = 0;
        img_done   = 1'b0;
    endfunction

    // one pixel at the current position, then step along the line / plane / row
    function automatic void put_pixel(logic [pcxrd_pkg::BYTE_W-1:0] v);
        int unsigned     w;
        int unsigned     h;
        longint unsigned off;
        t_pixel          p;
        w = width_reg;
        h = height_reg;
        if (w < 1) w = 1;
        if (w > pcxrd_pkg::DEF_MAX_WIDTH) w = pcxrd_pkg::DEF_MAX_WIDTH;
        if (h < 1) h = 1;
        if (h > pcxrd_pkg::DEF_MAX_HEIGHT) h = pcxrd_pkg::DEF_MAX_HEIGHT;
        if (img_done || row >= h) begin
            img_done = 1'b1;
            return;
        end
        off = longint'(row) * w + col;
        if (rgb_reg) off = off * 3 + ((plane > 2) ? 2 : plane);
        p.value       = v;
        p.offset      = off[pcxrd_pkg::OFFSET_W-1:0];
        p.run_end     = 1'b0;
        p.fills_image = 1'b0;
        col++;
        if (col >= w) begin
            col = 0;
            if (rgb_reg && plane < 2) begin
                plane++;
            end else begin
                plane = 0;
                row++;
                if (row >= h) begin
                    img_done      = 1'b1;
                    p.fills_image = 1'b1;
                end
            end
        end
        want_q.push_back(p);
    endfunction

    function automatic void predict_byte(logic [pcxrd_pkg::BYTE_W-1:0] b, logic frame_start);
        int queued;
        int k;
        if (frame_start) clear_position();
        if (img_done) return;
        queued = want_q.size();
        if (wait_value) begin
            wait_value = 1'b0;
            for (k = 0; k < run_left && !img_done; k++) put_pixel(b);
            run_left = '0;
        end else if (b[7:6] == pcxrd_pkg::MARKER_TAG) begin
            wait_value = 1'b1;
            run_left   = b[pcxrd_pkg::COUNT_W-1:0];
        end else begin
            put_pixel(b);
        end
        if (want_q.size() > queued) want_q[want_q.size()-1].run_end = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (!i_rst_n) begin
            width_reg  = pcxrd_pkg::RST_WIDTH;
            height_reg = pcxrd_pkg::RST_HEIGHT;
            rgb_reg    = 1'b0;
            clear_position();
            want_q.delete();
            o_errors = 0;
            o_bytes  = 0;
            o_pixels = 0;
            o_images = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pcxrd_pkg::CFG_IDX_WIDTH:  width_reg  = i_cfg_data;
                    pcxrd_pkg::CFG_IDX_HEIGHT: height_reg = i_cfg_data;
                    pcxrd_pkg::CFG_IDX_RGB:    rgb_reg    = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                o_bytes++;
                predict_byte(i_s_tdata[pcxrd_pkg::BYTE_W-1:0], i_s_tuser);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.value       = i_m_tdata[pcxrd_pkg::BYTE_W-1:0];
                got.offset      = i_m_tdata[pcxrd_pkg::BYTE_W +: pcxrd_pkg::OFFSET_W];
                got.run_end     = i_m_tlast;
                got.fills_image = i_m_tuser;
                if (want_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: pixel with nothing expected", $time);
                    $display("%0t: actual value %02h offset %0d last %b complete %b",
                             $time, got.value, got.offset, got.run_end, got.fills_image);
                end else begin
                    want = want_q.pop_front();
                    o_pixels++;
                    if (got.fills_image) o_images++;
                    if (got.value != want.value || got.offset != want.offset ||
                        got.run_end != want.run_end ||
                        got.fills_image != want.fills_image) begin
                        o_errors++;
                        $display("%0t: mismatch expected value %02h offset %0d last %b complete %b",
                                 $time, want.value, want.offset, want.run_end, want.fills_image);
                        $display("%0t:          actual   value %02h offset %0d last %b complete %b",
                                 $time, got.value, got.offset, got.run_end, got.fills_image);
                    end
                end
            end
        end
        o_pending = want_q.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// testbench top of the pcx byte run decoder: clock, reset, request and register stimulus, verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 80;

    logic                             clk;
    logic                             rst_n      = 1'b0;
    logic                             s_tvalid   = 1'b0;
    logic                             s_tready;
    logic [pcxrd_pkg::S_TDATA_W-1:0]  s_tdata    = '0;
    logic                             s_tuser    = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready   = 1'b0;
    logic [pcxrd_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                             m_tlast;
    logic                             m_tuser;
    logic                             cfg_we     = 1'b0;
    logic [pcxrd_pkg::CFG_IDX_W-1:0]  cfg_index  = pcxrd_pkg::CFG_IDX_WIDTH;
    logic [pcxrd_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

    logic calm      = 1'b0;
    int   hold_asks = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   sent      = 0;
    int   cycles    = 0;

    int errors;
    int pending;
    int bytes_in;
    int pixels_out;
    int images_done;

    pcx_byte_run_decoder uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    pcx_pixel_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tlast   (m_tlast),
        .i_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_bytes     (bytes_in),
        .o_pixels    (pixels_out),
        .o_images    (images_done)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 28);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // offer one request and wait for its handshake; tready is sampled mid-cycle
    task automatic send_byte(input logic [7:0] b, input logic fs);
        logic rdy;
        while (!calm && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fs;
        sent++;
        do begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end while (!rdy);
    endtask

    task automatic send_run(input int cnt, input logic [7:0] v, input logic fs);
        send_byte({pcxrd_pkg::MARKER_TAG, 6'(cnt)}, fs);
        send_byte(v, 1'b0);
    endtask

    // drain all expected pixels; a few extra cycles cover bytes that make none
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_geometry(input int w, input int h, input logic rgb);
        cfg_we    <= 1'b1;
        cfg_index <= pcxrd_pkg::CFG_IDX_WIDTH;
        cfg_data  <= w[pcxrd_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= pcxrd_pkg::CFG_IDX_HEIGHT;
        cfg_data  <= h[pcxrd_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_index <= pcxrd_pkg::CFG_IDX_RGB;
        cfg_data  <= {{(pcxrd_pkg::CFG_DATA_W-1){1'b0}}, rgb};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int  rand_base;
        int  phase;
        int  n_items;
        int  i;
        int  r;
        int  w;
        int  h;
        int  sel;
        int  cnt;
        logic fs;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry, 640 wide single plane
        send_byte(8'h12, 1'b1);
        send_run(4, 8'hAB, 1'b0);
        send_byte(8'h00, 1'b0);
        drain();

        // 4x2 mono: literal extremes, zero-length run, run cut off at image end
        set_geometry(4, 2, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hBF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h40, 1'b0);
        send_run(0, 8'h55, 1'b0);
        send_run(6, 8'hFF, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC1, 1'b0);
        drain();

        // 3x2 rgb, runs crossing plane lines
        set_geometry(3, 2, 1'b1);
        send_byte(8'h01, 1'b1);
        send_run(7, 8'h3C, 1'b0);
        send_run(63, 8'hEE, 1'b0);
        drain();

        // smallest image, then width and height clamping
        set_geometry(1, 1, 1'b0);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h11, 1'b0);
        drain();
        set_geometry(0, 8191, 1'b1);
        send_byte(8'h5A, 1'b1);
        send_run(5, 8'h99, 1'b0);
        drain();

        // one pixel per row down to a deep row, with the receiver held off
        set_geometry(1, 4096, 1'b0);
        hold_asks <= hold_asks + 1;
        send_byte(8'($urandom_range(191)), 1'b1);
        for (i = 0; i < 12; i++) send_run(63, 8'($urandom_range(255)), 1'b0);
        drain();

        // widen mid-frame so offsets grow large, then shrink below the row
        set_geometry(4096, 4096, 1'b1);
        send_byte(8'h21, 1'b0);
        send_byte(8'h9C, 1'b0);
        send_run(9, 8'h77, 1'b0);
        drain();
        set_geometry(4096, 100, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain();

        // column left past a narrowed width
        set_geometry(8, 3, 1'b0);
        send_byte(8'h01, 1'b1);
        send_run(6, 8'h42, 1'b0);
        drain();
        set_geometry(4, 3, 1'b0);
        send_byte(8'h30, 1'b0);
        send_byte(8'h31, 1'b0);
        drain();

        rand_base = sent;
        phase     = 0;
        while (sent - rand_base < RAND_ITEMS) begin
            sel = $urandom_range(9);
            w   = (sel == 0) ? 4096 : (sel == 1) ? 8191 : $urandom_range(1, 6);
            h   = (sel == 2) ? 4096 : (sel == 3) ? 0 : $urandom_range(1, 5);
            set_geometry(w, h, 1'($urandom_range(1)));
            calm <= (phase == 1);
            n_items = $urandom_range(12, 30);
            fs      = 1'b1;
            for (i = 0; i < n_items; i++) begin
                r = $urandom_range(99);
                if (r < 10) begin
                    send_byte(8'($urandom_range(255)), 1'b1);
                end else if (r < 55) begin
                    send_byte(8'($urandom_range(191)), fs);
                end else if (r < 93) begin
                    cnt = ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(12);
                    send_run(cnt, 8'($urandom_range(255)), fs);
                end else begin
                    send_byte(8'($urandom_range(255)), fs);
                end
                fs = 1'b0;
            end
            drain();
            phase++;
        end
        calm <= 1'b0;

        drain();
        repeat (8) @(posedge clk);
        $display("summary: %0d code bytes sent, %0d pixels checked, %0d images filled",
                 bytes_in, pixels_out, images_done);
        $display("summary: mono and rgb, widths and heights from 1 to clamped 4096, deep rows");
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/pcxrd_pkg.sv
src/pcxrd_ctrl.sv
src/pcxrd_dp.sv
src/pcx_byte_run_decoder.sv
tb/pcx_pixel_checker.sv
tb/tb_top.sv
